@@ rtl/a80_pkg.sv @@
// Package: payload types, commands and constants of the Ascon-80pq engine.
`default_nettype none
package a80_pkg;

    localparam logic [63:0] IV_80PQ = 64'ha0400c0600000000;

    typedef struct packed {
        logic [1:0]  func;
        logic        decrypt_mode;
        logic [63:0] data_in;
        logic [3:0]  byte_count;
        logic [63:0] nonce_hi;
        logic [63:0] nonce_lo;
        logic [63:0] expect_tag_hi;
        logic [63:0] expect_tag_lo;
    } in_item_t;

    typedef struct packed {
        logic        out_kind;
        logic [63:0] data_out;
        logic [3:0]  out_bytes;
        logic [63:0] tag_hi;
        logic [63:0] tag_lo;
        logic        tag_ok;
    } out_item_t;

    localparam logic [1:0] FN_START  = 2'd0;
    localparam logic [1:0] FN_AD     = 2'd1;
    localparam logic [1:0] FN_MSG    = 2'd2;
    localparam logic [1:0] FN_FINISH = 2'd3;

    localparam logic [1:0] CFG_KEY_TOP = 2'd0;
    localparam logic [1:0] CFG_KEY_MID = 2'd1;
    localparam logic [1:0] CFG_KEY_LOW = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_AD   = 2'd1;
    localparam logic [1:0] PH_MSG  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,      // load key, nonce, IV
        OP_INIT_KEY,  // xor key after init rounds
        OP_AD_FULL,   // xor full block
        OP_AD_LAST,   // xor masked block plus pad
        OP_PAD0,      // xor pad at byte 0
        OP_DSEP,      // domain separation bit
        OP_MSG,       // encrypt/decrypt block, capture result
        OP_FIN_KEY,   // xor key before finalization
        OP_TAG_KEY    // xor key after finalization, capture tag
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       round_en;   // run one permutation round
        logic [3:0] round_idx;  // round constant index 0..11
    } dp_cmd_t;

    // Byte mask of the first n bytes, n in 0..8
    function automatic logic [63:0] top_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < n) m[63-8*i -: 8] = 8'hff;
        end
        return m;
    endfunction

    // Pad bit after n bytes, n in 0..7
    function automatic logic [63:0] pad_bit(input logic [2:0] n);
        logic [63:0] p;
        p = '0;
        p[63 - 8*n] = 1'b1;
        return p;
    endfunction

endpackage
`default_nettype wire

@@ rtl/ascon80pq_aead_engine_top.sv @@
// Top level of the Ascon-80pq AEAD engine.
//
//  channel | ports                        | width/notes
//  in      | s_valid, s_ready, s_data     | in_item_t, valid/ready
//  out     | m_valid, m_ready, m_data     | out_item_t, valid/ready
//  config  | cfg_we, cfg_index, cfg_wdata | 2-bit index, 64-bit data
//
// One round per cycle on a single round unit.
// Closing the AD phase on a message or finish adds domain separation, and with an
// open block also the implicit pad rounds.
// Synchronous active-low reset clears control and key registers.
// Input is not taken while a result beat waits on m_ready.
`default_nettype none
module ascon80pq_aead_engine_top (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire a80_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output a80_pkg::out_item_t     m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_wdata
);
    import a80_pkg::*;

    dp_cmd_t     cmd;
    logic        dir;
    logic [31:0] k_top;
    logic [63:0] k_mid, k_low;
    in_item_t    item_reg;

    // Hold the accepted beat for multi-cycle commands
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) item_reg <= s_data;
    end

    a80_keyregs u_keys (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .key_top(k_top), .key_mid(k_mid), .key_low(k_low)
    );

    a80_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready,
        .item(s_ready ? s_data : item_reg),
        .m_valid, .m_ready, .cmd, .dir_decrypt(dir)
    );

    a80_datapath u_dp (
        .aclk, .cmd,
        .item(s_ready ? s_data : item_reg),
        .dir_decrypt(dir),
        .key_top(k_top), .key_mid(k_mid), .key_low(k_low),
        .result(m_data)
    );
endmodule
`default_nettype wire

@@ rtl/a80_datapath.sv @@
// Datapath: 320-bit sponge state, one Ascon round per cycle, key and result logic.
`default_nettype none
module a80_datapath (
    input  wire logic              aclk,
    input  wire a80_pkg::dp_cmd_t  cmd,
    input  wire a80_pkg::in_item_t item,
    input  wire logic              dir_decrypt,
    input  wire logic [31:0]       key_top,
    input  wire logic [63:0]       key_mid,
    input  wire logic [63:0]       key_low,
    output a80_pkg::out_item_t     result
);
    import a80_pkg::*;

    logic [63:0] x_reg  [5];
    logic [63:0] x_next [5];
    logic [63:0] r      [5];
    out_item_t   res_reg, res_next;
    logic [3:0]  n;
    logic [63:0] m, d, rd;
    logic [63:0] t0, t1, t2, t3, t4;
    logic [63:0] a0, a1, a2, a3, a4;
    logic [63:0] b0, b1, b2, b3, b4;
    logic [7:0]  rc;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int s);
        return (v >> s) | (v << (64 - s));
    endfunction

    assign n  = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
    assign m  = top_mask(n);
    assign d  = item.data_in & m;
    assign rc = {4'hf - cmd.round_idx, cmd.round_idx};

    // One permutation round
    always_comb begin
        a0 = x_reg[0] ^ x_reg[4];
        a4 = x_reg[4] ^ x_reg[3];
        a2 = x_reg[2] ^ {56'd0, rc} ^ x_reg[1];
        a1 = x_reg[1];
        a3 = x_reg[3];
        t0 = ~a0 & a1; t1 = ~a1 & a2; t2 = ~a2 & a3; t3 = ~a3 & a4; t4 = ~a4 & a0;
        b0 = a0 ^ t1; b1 = a1 ^ t2; b2 = a2 ^ t3; b3 = a3 ^ t4; b4 = a4 ^ t0;
        b1 = b1 ^ b0; b0 = b0 ^ b4; b3 = b3 ^ b2; b2 = ~b2;
        r[0] = b0 ^ rotr(b0, 19) ^ rotr(b0, 28);
        r[1] = b1 ^ rotr(b1, 61) ^ rotr(b1, 39);
        r[2] = b2 ^ rotr(b2, 1)  ^ rotr(b2, 6);
        r[3] = b3 ^ rotr(b3, 10) ^ rotr(b3, 17);
        r[4] = b4 ^ rotr(b4, 7)  ^ rotr(b4, 41);
    end

    // State update per command
    always_comb begin
        for (int i = 0; i < 5; i++) x_next[i] = x_reg[i];
        res_next = res_reg;
        rd = '0;
        if (cmd.round_en) begin
            for (int i = 0; i < 5; i++) x_next[i] = r[i];
        end
        case (cmd.op)
            OP_INIT: begin
                x_next[0] = IV_80PQ | {32'd0, key_top};
                x_next[1] = key_mid;
                x_next[2] = key_low;
                x_next[3] = item.nonce_hi;
                x_next[4] = item.nonce_lo;
            end
            OP_INIT_KEY: begin
                x_next[2] = x_reg[2] ^ {32'd0, key_top};
                x_next[3] = x_reg[3] ^ key_mid;
                x_next[4] = x_reg[4] ^ key_low;
            end
            OP_AD_FULL: x_next[0] = x_reg[0] ^ d;
            OP_AD_LAST: x_next[0] = x_reg[0] ^ d ^ pad_bit(n[2:0]);
            OP_PAD0:    x_next[0] = x_reg[0] ^ pad_bit(3'd0);
            OP_DSEP:    x_next[4] = x_reg[4] ^ 64'd1;
            OP_MSG: begin
                if (dir_decrypt) begin
                    rd = (x_reg[0] ^ d) & m;
                    x_next[0] = (x_reg[0] & ~m) | d;
                end else begin
                    x_next[0] = x_reg[0] ^ d;
                    rd = x_next[0] & m;
                end
                if (n != 4'd8) x_next[0] = x_next[0] ^ pad_bit(n[2:0]);
                res_next = '0;
                res_next.data_out  = rd;
                res_next.out_bytes = n;
            end
            OP_FIN_KEY: begin
                x_next[1] = x_reg[1] ^ {key_top, key_mid[63:32]};
                x_next[2] = x_reg[2] ^ {key_mid[31:0], key_low[63:32]};
                x_next[3] = x_reg[3] ^ {key_low[31:0], 32'd0};
            end
            OP_TAG_KEY: begin
                x_next[3] = x_reg[3] ^ key_mid;
                x_next[4] = x_reg[4] ^ key_low;
                res_next = '0;
                res_next.out_kind = 1'b1;
                res_next.tag_hi   = x_next[3];
                res_next.tag_lo   = x_next[4];
                res_next.tag_ok   = dir_decrypt && x_next[3] == item.expect_tag_hi
                                    && x_next[4] == item.expect_tag_lo;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 5; i++) x_reg[i] <= x_next[i];
        res_reg <= res_next;
    end

    assign result = res_reg;
endmodule
`default_nettype wire

@@ rtl/a80_ctrl.sv @@
// Controller: phase tracking and sequencing of the round datapath.
`default_nettype none
module a80_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire a80_pkg::in_item_t item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output a80_pkg::dp_cmd_t       cmd,
    output logic                   dir_decrypt
);
    import a80_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_INIT   = 7'b0000010,  // 12 rounds, then key xor
        ST_ADR    = 7'b0000100,  // 6 rounds for an AD block
        ST_CLOSE  = 7'b0001000,  // 6 rounds for implicit pad, then dsep and pending op
        ST_MSGR   = 7'b0010000,  // 6 rounds after a full message block
        ST_FINR   = 7'b0100000,  // 12 rounds, then tag
        ST_OUT    = 7'b1000000   // result waiting
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] rnd_reg, rnd_next;
    logic [1:0] phase_reg, phase_next;
    logic       dir_reg, dir_next;
    logic       adop_reg, adop_next;
    logic       fin_reg, fin_next;    // pending op after close: 0 msg, 1 finish
    logic       outv_reg, outv_next;
    logic       accept;
    logic [3:0] n;

    assign n       = (item.byte_count > 4'd8) ? 4'd8 : item.byte_count;
    assign s_ready = (state_reg == ST_IDLE) && !outv_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = outv_reg;
    assign dir_decrypt = dir_reg;

    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        phase_next = phase_reg;
        dir_next   = dir_reg;
        adop_next  = adop_reg;
        fin_next   = fin_reg;
        outv_next  = outv_reg && !m_ready;
        cmd        = '{op: OP_NONE, round_en: 1'b0, round_idx: rnd_reg};
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (item.func)
                        FN_START: begin
                            cmd.op     = OP_INIT;
                            dir_next   = item.decrypt_mode;
                            rnd_next   = 4'd0;
                            state_next = ST_INIT;
                        end
                        FN_AD: begin
                            if (phase_reg == PH_AD) begin
                                if (n == 4'd8) begin
                                    cmd.op     = OP_AD_FULL;
                                    adop_next  = 1'b1;
                                    rnd_next   = 4'd6;
                                    state_next = ST_ADR;
                                end else if (n != 4'd0 || adop_reg) begin
                                    cmd.op     = OP_AD_LAST;
                                    adop_next  = 1'b0;
                                    rnd_next   = 4'd6;
                                    state_next = ST_ADR;
                                end else begin
                                    cmd.op     = OP_DSEP;
                                    phase_next = PH_MSG;
                                end
                            end
                        end
                        default: begin
                            // message or finish
                            if (phase_reg == PH_AD) begin
                                fin_next  = (item.func == FN_FINISH);
                                adop_next = 1'b0;
                                if (adop_reg) begin
                                    cmd.op     = OP_PAD0;
                                    rnd_next   = 4'd6;
                                    state_next = ST_CLOSE;
                                end else begin
                                    cmd.op     = OP_DSEP;
                                    phase_next = PH_MSG;
                                    state_next = ST_CLOSE;
                                    rnd_next   = 4'd12;
                                end
                            end else if (item.func == FN_MSG) begin
                                if (phase_reg == PH_MSG) begin
                                    cmd.op    = OP_MSG;
                                    outv_next = 1'b1;
                                    if (n == 4'd8) begin
                                        rnd_next   = 4'd6;
                                        state_next = ST_MSGR;
                                    end else begin
                                        phase_next = PH_DONE;
                                    end
                                end
                            end else if (phase_reg != PH_IDLE) begin
                                cmd.op     = (phase_reg == PH_MSG) ? OP_PAD0 : OP_NONE;
                                fin_next   = 1'b1;
                                state_next = ST_CLOSE;
                                rnd_next   = 4'd13;
                            end
                        end
                    endcase
                end
            end
            ST_INIT: begin
                if (rnd_reg == 4'd12) begin
                    cmd.op     = OP_INIT_KEY;
                    phase_next = PH_AD;
                    adop_next  = 1'b0;
                    state_next = ST_IDLE;
                end else begin
                    cmd.round_en = 1'b1;
                    rnd_next     = rnd_reg + 4'd1;
                end
            end
            ST_ADR, ST_MSGR: begin
                cmd.round_en = 1'b1;
                rnd_next     = rnd_reg + 4'd1;
                if (rnd_reg == 4'd11) begin
                    state_next = (state_reg == ST_MSGR) ? ST_OUT : ST_IDLE;
                    if (state_reg == ST_ADR && !adop_reg) begin
                        state_next = ST_CLOSE;
                        rnd_next   = 4'd14;
                    end
                end
            end
            ST_CLOSE: begin
                // rnd 6..11: pad rounds; 12: dsep if phase is still AD, then dispatch;
                // 13: pad-for-finish done, go finalize; 14: AD final, dsep
                if (rnd_reg < 4'd12) begin
                    cmd.round_en = 1'b1;
                    rnd_next     = rnd_reg + 4'd1;
                    if (rnd_reg == 4'd11) begin
                        cmd.op = OP_NONE;
                    end
                end else if (rnd_reg == 4'd14) begin
                    cmd.op     = OP_DSEP;
                    phase_next = PH_MSG;
                    state_next = ST_IDLE;
                end else if (rnd_reg == 4'd12 && phase_reg == PH_AD) begin
                    cmd.op     = OP_DSEP;
                    phase_next = PH_MSG;
                end else if (rnd_reg == 4'd12) begin
                    // phase is message now: redo the pending item
                    if (!fin_reg) begin
                        cmd.op    = OP_MSG;
                        outv_next = 1'b1;
                        if (n == 4'd8) begin
                            rnd_next   = 4'd6;
                            state_next = ST_MSGR;
                        end else begin
                            phase_next = PH_DONE;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        cmd.op   = OP_PAD0;
                        rnd_next = 4'd13;
                    end
                end else begin
                    cmd.op     = OP_FIN_KEY;
                    rnd_next   = 4'd0;
                    state_next = ST_FINR;
                end
            end
            ST_FINR: begin
                if (rnd_reg == 4'd12) begin
                    cmd.op     = OP_TAG_KEY;
                    outv_next  = 1'b1;
                    phase_next = PH_IDLE;
                    state_next = ST_IDLE;
                end else begin
                    cmd.round_en = 1'b1;
                    rnd_next     = rnd_reg + 4'd1;
                end
            end
            ST_OUT: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            phase_reg <= PH_IDLE;
            dir_reg   <= 1'b0;
            adop_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            outv_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            adop_reg  <= adop_next;
            fin_reg   <= fin_next;
            outv_reg  <= outv_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/a80_keyregs.sv @@
// Key configuration registers of the Ascon-80pq engine.
`default_nettype none
module a80_keyregs (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    output logic [31:0]      key_top,
    output logic [63:0]      key_mid,
    output logic [63:0]      key_low
);
    import a80_pkg::*;

    logic [31:0] top_reg;
    logic [63:0] mid_reg, low_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg <= '0;
            mid_reg <= '0;
            low_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KEY_TOP: top_reg <= cfg_wdata[31:0];
                CFG_KEY_MID: mid_reg <= cfg_wdata;
                CFG_KEY_LOW: low_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign key_top = top_reg;
    assign key_mid = mid_reg;
    assign key_low = low_reg;
endmodule
`default_nettype wire
